// ----- hw/rtl/lphm_pkg.sv -----
// Shared types and constants for the linear-probe hash map.
// No dependencies.
package lphm_pkg;
    localparam int unsigned TableDepth = 256;
    localparam int unsigned IdxW = $clog2(TableDepth);
    localparam int unsigned LenW = 12;
    localparam int unsigned CntW = $clog2(TableDepth + 1);
    localparam logic [31:0] HashMult = 32'd2654435761;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_LIVE    = 2'd1,
        MARK_DELETED = 2'd2
    } mark_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;       // capture input word and hash
        logic hash;       // form home slot from product
        logic rd;         // issue read at probe index
        logic adv;        // advance probe index
        logic write_hit;  // update value at probe slot
        logic write_new;  // write new entry at chosen slot
        logic write_del;  // mark probe slot deleted
        logic clr_step;   // clear one slot at clear index
        logic clr_start;
        logic finish;     // form result
        status_t status;
        logic found;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        action_t action;
        logic    is_empty;
        logic    is_hit;
        logic    have_del;
        logic    probe_last;
        logic    clr_last;
    } stat_t;
endpackage

// ----- hw/rtl/lphm_datapath.sv -----
// Datapath of the hash map: slot memories, hashing, probe index and counts.
// Depends on lphm_pkg.
module lphm_datapath
    import lphm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [77:0]     in_word,
    input  cmd_t            cmd,
    output stat_t           stat,
    output logic [55:0]     res_word
);
    logic [1:0]      mark_mem [TableDepth];
    logic [31:0]     key_mem  [TableDepth];
    logic [31:0]     val_mem  [TableDepth];
    logic [LenW-1:0] len_mem  [TableDepth];

    action_t         action_reg;
    logic [31:0]     key_reg, val_reg, prod_reg, rkey_reg, rval_reg;
    logic [LenW-1:0] len_reg, rlen_reg;
    logic [1:0]      rmark_reg;
    logic [IdxW-1:0] idx_reg, del_idx_reg, clr_reg;
    logic [IdxW:0]   n_reg;
    logic            have_del_reg;
    logic [CntW-1:0] entry_reg, deleted_reg;
    logic [CntW-1:0] entry_next;
    logic            lookup_hit;
    logic [55:0]     res_reg;

    // The result carries the live count after this action has taken effect.
    assign entry_next = cmd.write_new ? entry_reg + 1'b1 :
                        (cmd.write_del ? entry_reg - 1'b1 : entry_reg);
    assign lookup_hit = cmd.found && action_reg == ACT_LOOKUP;

    // Mark memory is cleared by a sweep after reset and on clear.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mark_mem[clr_reg] <= MARK_EMPTY;
        end
        else if (cmd.write_new)
        begin
            mark_mem[have_del_reg ? del_idx_reg : idx_reg] <= MARK_LIVE;
        end
        else if (cmd.write_del)
        begin
            mark_mem[idx_reg] <= MARK_DELETED;
        end
        if (cmd.write_new)
        begin
            key_mem[have_del_reg ? del_idx_reg : idx_reg] <= key_reg;
            val_mem[have_del_reg ? del_idx_reg : idx_reg] <= val_reg;
            len_mem[have_del_reg ? del_idx_reg : idx_reg] <= len_reg;
        end
        else if (cmd.write_hit)
        begin
            val_mem[idx_reg] <= val_reg;
            len_mem[idx_reg] <= len_reg;
        end
        if (cmd.rd)
        begin
            rmark_reg <= mark_mem[idx_reg];
            rkey_reg  <= key_mem[idx_reg];
            rval_reg  <= val_mem[idx_reg];
            rlen_reg  <= len_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action_t'(in_word[1:0]);
            key_reg    <= in_word[33:2];
            val_reg    <= in_word[65:34];
            len_reg    <= in_word[77:66];
            prod_reg   <= in_word[33:2] * HashMult;
        end
        if (cmd.finish)
        begin
            res_reg <= {entry_next, lookup_hit ? rlen_reg : LenW'(0),
                        lookup_hit ? rval_reg : 32'd0, cmd.found, cmd.status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            del_idx_reg  <= '0;
            n_reg        <= '0;
            have_del_reg <= 1'b0;
            clr_reg      <= '0;
            entry_reg    <= '0;
            deleted_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_start)
            begin
                clr_reg     <= '0;
                entry_reg   <= '0;
                deleted_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.hash)
            begin
                idx_reg      <= prod_reg[IdxW-1:0];
                n_reg        <= '0;
                have_del_reg <= 1'b0;
            end
            else if (cmd.adv)
            begin
                if (rmark_reg == MARK_DELETED && !have_del_reg)
                begin
                    have_del_reg <= 1'b1;
                    del_idx_reg  <= idx_reg;
                end
                idx_reg <= idx_reg + 1'b1;
                n_reg   <= n_reg + 1'b1;
            end
            if (cmd.write_new)
            begin
                entry_reg <= entry_reg + 1'b1;
                if ((have_del_reg || rmark_reg == MARK_DELETED) && deleted_reg != '0)
                begin
                    deleted_reg <= deleted_reg - 1'b1;
                end
            end
            if (cmd.write_del)
            begin
                entry_reg   <= entry_reg - 1'b1;
                deleted_reg <= deleted_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.action     = action_reg;
        stat.is_empty   = rmark_reg == MARK_EMPTY;
        stat.is_hit     = rmark_reg == MARK_LIVE && rkey_reg == key_reg;
        stat.have_del   = have_del_reg || rmark_reg == MARK_DELETED;
        stat.probe_last = n_reg == (IdxW + 1)'(TableDepth - 1);
        stat.clr_last   = clr_reg == IdxW'(TableDepth - 1);
    end

    assign res_word = res_reg;
endmodule

// ----- hw/rtl/lphm_ctrl.sv -----
// Controller of the hash map: sequences hashing, probing, writes and clears.
// Depends on lphm_pkg.
module lphm_ctrl
    import lphm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);
    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_HASH, S_READ, S_CHECK, S_CLEAR, S_OUT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.status = ST_DONE;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
            end
            S_IDLE:
            begin
                cmd.load = in_valid;
            end
            S_HASH:
            begin
                if (stat.action == ACT_CLEAR)
                begin
                    cmd.clr_start = 1'b1;
                end
                else
                begin
                    cmd.hash = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.rd = 1'b1;
            end
            S_CHECK:
            begin
                if (stat.is_hit)
                begin
                    cmd.finish = 1'b1;
                    cmd.found  = stat.action != ACT_INSERT;
                    cmd.write_hit = stat.action == ACT_INSERT;
                    cmd.write_del = stat.action == ACT_DELETE;
                end
                else if (stat.is_empty || stat.probe_last)
                begin
                    cmd.finish = 1'b1;
                    if (stat.action == ACT_INSERT)
                    begin
                        if (stat.is_empty || stat.have_del)
                        begin
                            cmd.write_new = 1'b1;
                        end
                        else
                        begin
                            cmd.status = ST_FULL;
                        end
                    end
                    else
                    begin
                        cmd.status = ST_NOTFOUND;
                    end
                end
                else
                begin
                    cmd.adv = 1'b1;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                cmd.finish   = stat.clr_last;
            end
            default:
            begin
                cmd.status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_INIT:
                begin
                    if (stat.clr_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    state_reg <= (stat.action == ACT_CLEAR) ? S_CLEAR : S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (cmd.finish)
                    begin
                        state_reg     <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_CLEAR:
                begin
                    if (stat.clr_last)
                    begin
                        state_reg     <= S_OUT;
                        out_valid_reg <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- hw/rtl/linear_probe_hash_map.sv -----
// Top level of the linear-probe hash map: joins controller and datapath.
// Depends on lphm_pkg, lphm_ctrl and lphm_datapath.
//
// Channel  Direction  Payload
// s_axis   in         action, key, value_word, value_length
// m_axis   out        status, found, value_out, length_out, live_count
//
// An action probes slot after slot from the home slot; a clear sweeps every slot.
// The single-port slot memories are read once per probe step.
// After reset a sweep empties the slot marks before the first word.
// A result waits in the output register until taken; no new word is taken
// until then.
module linear_probe_hash_map
    import lphm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], key[33:2], value_word[65:34], value_length[77:66], zero
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], found[2], value_out[34:3], length_out[46:35],
    // live_count[55:47]
    output logic [55:0] m_axis_tdata
);
    cmd_t  cmd;
    stat_t stat;

    lphm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lphm_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (s_axis_tdata[77:0]),
        .cmd      (cmd),
        .stat     (stat),
        .res_word (m_axis_tdata)
    );
endmodule

// ----- hw/rtl/lphm_checker.sv -----
// Port-level checks for the hash map, bound to the top level.
// Depends on linear_probe_hash_map.
module lphm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[55:47] <= 9'd256) else $error("count too big");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad status");
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == 2'd0)
        else $error("found with error status");
endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (.*);
